### hw/rtl/ffbcc_pkg.sv
// Frame flag and BCC checker: shared constants and types.
// Used by the top level, the frame state and the testbench; depends on nothing.
`timescale 1ns / 1ps

package ffbcc_pkg;

	localparam int SUFFIX_LEN = 8;
	localparam int FLAG_W     = 32;
	localparam int BYTE_W     = 8;
	localparam int COUNT_W    = 5;
	localparam int HEAD_LEN   = 4;
	localparam int CFG_IDX_W  = 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [FLAG_W-1:0] flag_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_HEAD  = 3'd1,
		ST_TAIL  = 3'd2,
		ST_CHECK = 3'd3,
		ST_SHORT = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAD_MARK = 1'b0,
		REG_TAIL_MARK = 1'b1
	} reg_idx_t;

	// Item handed from the input register to the frame state.
	typedef struct packed {
		logic  step;
		byte_t data;
		logic  last;
	} step_t;

endpackage

### hw/rtl/frame_flag_and_bcc_checker.sv
// Frame flag and BCC checker: top level with input, config and result registers.
// Depends on ffbcc_pkg and ffbcc_frame_state.
// The status of a frame is registered as its last item leaves the input register.
// Throughput: one item per cycle; input stalls only while a finished status is held.
// Reset: arst_n clears flags, byte count, BCC and both valid registers at once.
`timescale 1ns / 1ps

module frame_flag_and_bcc_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         data_byte,
	input  logic                               last_byte,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         status,
	input  logic                               cfg_write_en,
	input  logic [ffbcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                        cfg_data
);

	ffbcc_pkg::flag_t   head_mark_q;
	ffbcc_pkg::flag_t   tail_mark_q;
	logic               valid_s1;
	ffbcc_pkg::byte_t   data_s1;
	logic               last_s1;
	logic               out_valid_q;
	ffbcc_pkg::status_t status_q;
	ffbcc_pkg::status_t frame_status;
	ffbcc_pkg::step_t   step;
	logic               out_free;
	logic               advance;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !advance;

	assign step.step = advance;
	assign step.data = data_s1;
	assign step.last = last_s1;

	ffbcc_frame_state u_frame_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_in    (step),
		.head_mark  (head_mark_q),
		.tail_mark  (tail_mark_q),
		.status_out (frame_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_mark_q <= '0;
			tail_mark_q <= '0;
		end else if (cfg_write_en) begin
			unique case (ffbcc_pkg::reg_idx_t'(cfg_index))
				ffbcc_pkg::REG_HEAD_MARK: head_mark_q <= cfg_data;
				ffbcc_pkg::REG_TAIL_MARK: tail_mark_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && last_s1) begin
			status_q <= frame_status;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

endmodule

### hw/rtl/ffbcc_frame_state.sv
// Frame state of the checker: head word, byte count, tail window and BCC.
// Gives the status of a frame on its last item. Depends on ffbcc_pkg.
`timescale 1ns / 1ps

module ffbcc_frame_state (
	input  logic               clk,
	input  logic               arst_n,
	input  ffbcc_pkg::step_t   step_in,
	input  ffbcc_pkg::flag_t   head_mark,
	input  ffbcc_pkg::flag_t   tail_mark,
	output ffbcc_pkg::status_t status_out
);

	ffbcc_pkg::flag_t  head_q;
	ffbcc_pkg::count_t count_q;
	ffbcc_pkg::byte_t  xor_q;
	ffbcc_pkg::byte_t  win_q [ffbcc_pkg::SUFFIX_LEN];

	ffbcc_pkg::flag_t  head_n;
	ffbcc_pkg::count_t count_n;
	ffbcc_pkg::byte_t  xor_n;
	ffbcc_pkg::byte_t  win_n [ffbcc_pkg::SUFFIX_LEN];
	ffbcc_pkg::flag_t  tail_word;

	always_comb begin
		head_n = head_q;
		if (count_q < ffbcc_pkg::COUNT_W'(ffbcc_pkg::HEAD_LEN)) begin
			head_n[{count_q[1:0], 3'b000} +: ffbcc_pkg::BYTE_W] = step_in.data;
		end
		xor_n = xor_q;
		if (count_q >= ffbcc_pkg::COUNT_W'(ffbcc_pkg::SUFFIX_LEN)) begin
			xor_n = xor_q ^ win_q[0];
		end
		for (int i = 0; i < ffbcc_pkg::SUFFIX_LEN - 1; i++) begin
			win_n[i] = win_q[i + 1];
		end
		win_n[ffbcc_pkg::SUFFIX_LEN - 1] = step_in.data;
		count_n = (count_q == ffbcc_pkg::COUNT_MAX) ? count_q :
			count_q + ffbcc_pkg::COUNT_W'(1);
		for (int k = 0; k < ffbcc_pkg::HEAD_LEN; k++) begin
			tail_word[ffbcc_pkg::BYTE_W * k +: ffbcc_pkg::BYTE_W] =
				win_n[ffbcc_pkg::SUFFIX_LEN - ffbcc_pkg::HEAD_LEN + k];
		end
	end

	always_comb begin
		priority if (count_n < ffbcc_pkg::COUNT_W'(ffbcc_pkg::SUFFIX_LEN)) begin
			status_out = ffbcc_pkg::ST_SHORT;
		end else if (head_n != head_mark) begin
			status_out = ffbcc_pkg::ST_HEAD;
		end else if (tail_word != tail_mark) begin
			status_out = ffbcc_pkg::ST_TAIL;
		end else if (xor_n != win_n[0]) begin
			status_out = ffbcc_pkg::ST_CHECK;
		end else begin
			status_out = ffbcc_pkg::ST_OK;
		end
	end

	// Clear count and BCC at the end of a frame; the payload is rewritten before use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			xor_q   <= '0;
		end else if (step_in.step) begin
			if (step_in.last) begin
				count_q <= '0;
				xor_q   <= '0;
			end else begin
				count_q <= count_n;
				xor_q   <= xor_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_in.step) begin
			head_q <= head_n;
			win_q  <= win_n;
		end
	end

endmodule

### hw/rtl/ffbcc_checker.sv
// Port-level checks for the frame flag and BCC checker, bound to the top level.
// Depends on frame_flag_and_bcc_checker.
`timescale 1ns / 1ps

module ffbcc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       last_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("status changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held status");

	a_mid_frame_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last_byte |=> !in_stall)
		else $error("input stalled behind a mid-frame item");

endmodule

bind frame_flag_and_bcc_checker ffbcc_checker u_ffbcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.last_byte (last_byte),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status)
);

### dv/tb_top.sv
// Testbench for frame_flag_and_bcc_checker: frames of bytes against a frame status tracker.
// Directed frames, then random frames under several flag settings with random stalls.
// Depends on ffbcc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;

	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_ITEMS = 300;
	localparam int BUF_LEN     = 64;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte    = '0;
	logic        last_byte    = 1'b0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [2:0]  status;
	logic        cfg_write_en = 1'b0;
	logic [ffbcc_pkg::CFG_IDX_W-1:0] cfg_index = ffbcc_pkg::REG_HEAD_MARK;
	logic [31:0] cfg_data     = '0;

	ffbcc_pkg::flag_t   flag_head = '0;
	ffbcc_pkg::flag_t   flag_tail = '0;
	ffbcc_pkg::flag_t   frm_head  = '0;
	ffbcc_pkg::count_t  frm_count = '0;
	ffbcc_pkg::byte_t   frm_window [ffbcc_pkg::SUFFIX_LEN];
	ffbcc_pkg::byte_t   frm_bcc   = '0;
	ffbcc_pkg::status_t status_due [$];
	ffbcc_pkg::byte_t   frame_buf [BUF_LEN];
	bit      idle_en    = 1'b1;
	int      bytes_sent = 0;
	int      mismatches = 0;
	int      quiet      = 0;

	frame_flag_and_bcc_checker u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		for (int k = 0; k < ffbcc_pkg::SUFFIX_LEN; k++) frm_window[k] = '0;
	end

	function automatic ffbcc_pkg::status_t frame_verdict();
		ffbcc_pkg::flag_t tail;
		if (frm_count < ffbcc_pkg::SUFFIX_LEN || frm_count < ffbcc_pkg::HEAD_LEN)
			return ffbcc_pkg::ST_SHORT;
		if (frm_head != flag_head)
			return ffbcc_pkg::ST_HEAD;
		tail = {frm_window[ffbcc_pkg::SUFFIX_LEN-1], frm_window[ffbcc_pkg::SUFFIX_LEN-2],
			frm_window[ffbcc_pkg::SUFFIX_LEN-3], frm_window[ffbcc_pkg::SUFFIX_LEN-4]};
		if (tail != flag_tail)
			return ffbcc_pkg::ST_TAIL;
		if (frm_bcc != frm_window[0])
			return ffbcc_pkg::ST_CHECK;
		return ffbcc_pkg::ST_OK;
	endfunction

	function automatic void track_frame_byte(input ffbcc_pkg::byte_t b, input logic l);
		if (frm_count < ffbcc_pkg::HEAD_LEN)
			frm_head[8*frm_count +: 8] = b;
		if (frm_count >= ffbcc_pkg::SUFFIX_LEN)
			frm_bcc ^= frm_window[0];
		for (int k = 0; k < ffbcc_pkg::SUFFIX_LEN - 1; k++) frm_window[k] = frm_window[k+1];
		frm_window[ffbcc_pkg::SUFFIX_LEN-1] = b;
		if (frm_count != ffbcc_pkg::COUNT_MAX)
			frm_count++;
		if (l) begin
			status_due.push_back(frame_verdict());
			frm_head  = '0;
			frm_count = '0;
			frm_bcc   = '0;
			for (int k = 0; k < ffbcc_pkg::SUFFIX_LEN; k++) frm_window[k] = '0;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			track_frame_byte(data_byte, last_byte);
	end

	always @(posedge clk) begin
		ffbcc_pkg::status_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (status_due.size() == 0) begin
				$display("%0t: status expected none, got %0d", $time, status);
				mismatches++;
			end else begin
				due = status_due.pop_front();
				if (status !== due) begin
					$display("%0t: status expected %0d, got %0d", $time, due, status);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet <= 0;
		else if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("Mismatches found");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	initial begin
		int burst;
		burst = 0;
		forever begin
			@(negedge clk);
			if (burst > 0) begin
				out_stall = 1'b1;
				burst--;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				out_stall = 1'b1;
				burst = $urandom_range(1, 10) - 1;
			end else
				out_stall = 1'b0;
		end
	end

	task automatic send_byte(input ffbcc_pkg::byte_t b, input logic l);
		int gap;
		@(negedge clk);
		if (idle_en && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		data_byte = b;
		last_byte = l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(input int len);
		for (int k = 0; k < len; k++) send_byte(frame_buf[k], k == len - 1);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (status_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Call only at a falling edge with the block drained.
	task automatic write_flag(input ffbcc_pkg::reg_idx_t idx, input ffbcc_pkg::flag_t v);
		cfg_write_en = 1'b1;
		cfg_index    = idx;
		cfg_data     = v;
		@(negedge clk);
		cfg_write_en = 1'b0;
		if (idx == ffbcc_pkg::REG_HEAD_MARK)
			flag_head = v;
		else
			flag_tail = v;
	endtask

	task automatic random_frame();
		int    len;
		int    pick;
		int    pos;
		ffbcc_pkg::byte_t bcc;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			len = $urandom_range(1, ffbcc_pkg::SUFFIX_LEN - 1);
		else if (pick < 20)
			len = $urandom_range(ffbcc_pkg::SUFFIX_LEN,
				ffbcc_pkg::SUFFIX_LEN + ffbcc_pkg::HEAD_LEN - 1);
		else if (pick < 85)
			len = $urandom_range(ffbcc_pkg::SUFFIX_LEN + ffbcc_pkg::HEAD_LEN, 30);
		else
			len = $urandom_range(31, 60);
		for (int k = 0; k < len; k++) frame_buf[k] = ffbcc_pkg::byte_t'($urandom);
		// mostly well formed: head, tail, then the check byte over everything before it
		if ($urandom_range(0, 9) != 0) begin
			if (len >= ffbcc_pkg::HEAD_LEN) begin
				for (int k = 0; k < ffbcc_pkg::HEAD_LEN; k++)
					frame_buf[k] = flag_head[8*k +: 8];
				for (int k = 0; k < 4; k++) frame_buf[len-4+k] = flag_tail[8*k +: 8];
			end
			if (len >= ffbcc_pkg::SUFFIX_LEN) begin
				bcc = '0;
				for (int k = 0; k < len - ffbcc_pkg::SUFFIX_LEN; k++) bcc ^= frame_buf[k];
				frame_buf[len-ffbcc_pkg::SUFFIX_LEN] = bcc;
			end
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 2)) begin
					case ($urandom_range(0, 3))
						0: pos = $urandom_range(0, ffbcc_pkg::HEAD_LEN - 1);
						1: pos = len - 1 - $urandom_range(0, 3);
						2: pos = len - ffbcc_pkg::SUFFIX_LEN;
						default: pos = $urandom_range(0, len - 1);
					endcase
					if (pos < 0)
						pos = 0;
					frame_buf[pos] ^= ffbcc_pkg::byte_t'(1) << $urandom_range(0, 7);
				end
			end
		end
		send_frame(len);
	endtask

	task automatic test_reset_flags();
		for (int k = 0; k < ffbcc_pkg::SUFFIX_LEN; k++) frame_buf[k] = 8'h00;
		send_frame(ffbcc_pkg::SUFFIX_LEN);
	endtask

	task automatic test_short_frames();
		frame_buf[0] = 8'hFF;
		send_frame(1);
		frame_buf[0] = 8'h80;
		frame_buf[1] = 8'h7F;
		frame_buf[2] = 8'h01;
		send_frame(3);
	endtask

	task automatic test_error_order();
		drain();
		write_flag(ffbcc_pkg::REG_HEAD_MARK, 32'hFFFF_FFFF);
		write_flag(ffbcc_pkg::REG_TAIL_MARK, 32'h0000_0000);
		for (int k = 0; k < ffbcc_pkg::SUFFIX_LEN; k++) frame_buf[k] = 8'hA5;
		send_frame(ffbcc_pkg::SUFFIX_LEN);
		for (int k = 0; k < ffbcc_pkg::HEAD_LEN; k++) frame_buf[k] = 8'hFF;
		send_frame(ffbcc_pkg::SUFFIX_LEN);
	endtask

	task automatic test_random_frames();
		ffbcc_pkg::flag_t v;
		int    target;
		for (int p = 0; p < 6; p++) begin
			drain();
			case (p)
				0: begin
					write_flag(ffbcc_pkg::REG_HEAD_MARK, '0);
					write_flag(ffbcc_pkg::REG_TAIL_MARK, '1);
				end
				1: begin
					write_flag(ffbcc_pkg::REG_HEAD_MARK, '1);
					write_flag(ffbcc_pkg::REG_TAIL_MARK, '0);
				end
				3: begin
					v = $urandom;
					write_flag(ffbcc_pkg::REG_HEAD_MARK, v);
					write_flag(ffbcc_pkg::REG_TAIL_MARK, v);
				end
				default: begin
					write_flag(ffbcc_pkg::REG_HEAD_MARK, $urandom);
					write_flag(ffbcc_pkg::REG_TAIL_MARK, $urandom);
				end
			endcase
			// no stalls in the final stretch
			idle_en = (p != 5);
			target = bytes_sent + PHASE_ITEMS;
			while (bytes_sent < target) random_frame();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_flags();
		test_short_frames();
		test_error_order();
		test_random_frames();
		drain();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
